FILE: sv/sks_pkg.sv
// shared types and constants for the sorted key set
// used by sks_cell and sorted_key_set; depends on nothing else

package sks_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_DUP    = 2'd1,
        STATUS_ABSENT = 2'd2,
        STATUS_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN
    } state_t;

    typedef struct packed {
        action_t                   action;
        logic signed [KEY_W-1:0]   key;
    } in_t;

    typedef struct packed {
        status_t                   status;
        logic [3:0]                position;
        logic [4:0]                entry_count;
        logic                      is_empty;
        logic signed [KEY_W-1:0]   first_key;
        logic signed [KEY_W-1:0]   last_key;
    } out_t;

    // shift commands broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctl_t;

    // per-cell compare results
    typedef struct packed {
        logic lt;
        logic eq;
        logic at_rank;
        logic is_last;
    } cell_flags_t;

endpackage

FILE: sv/sks_cell.sv
// one cell of the sorted key row: holds one key, compares it and shifts
// depends on sks_pkg

module sks_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                             clk,
    input  logic [CW-1:0]                    count,
    input  logic signed [sks_pkg::KEY_W-1:0] req_key,
    input  sks_pkg::cell_ctl_t               ctl,
    input  logic                             prev_lt,
    input  logic signed [sks_pkg::KEY_W-1:0] left_key,
    input  logic signed [sks_pkg::KEY_W-1:0] right_key,
    output logic signed [sks_pkg::KEY_W-1:0] key,
    output sks_pkg::cell_flags_t             flags
);

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

    logic signed [sks_pkg::KEY_W-1:0] key_reg;
    logic signed [sks_pkg::KEY_W-1:0] key_next;
    logic                             valid;

    assign valid = IDX_C < count;
    assign key   = key_reg;

    always_comb
    begin
        flags.lt      = valid && (key_reg < req_key);
        flags.eq      = valid && (key_reg == req_key);
        // first cell not below the request key
        flags.at_rank = !flags.lt && prev_lt;
        flags.is_last = count == IDX_P1;
    end

    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins && !flags.lt)
        begin
            key_next = prev_lt ? req_key : left_key;
        end
        else if (ctl.del && !flags.lt)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

FILE: sv/sorted_key_set.sv
// top level of the sorted key set: control sequencer over a row of cells
// depends on sks_pkg and sks_cell

// Holds up to CAPACITY distinct signed keys in ascending order, one key per
// cell in a row of compare-and-shift cells. Each request word (insert,
// delete, search, clear) passes through ST_IDLE, which accepts it, ST_EXEC,
// in which every cell compares against the key and the row shifts right
// (insert) or left (delete) in a single step, and ST_FIN, in which the end
// keys are picked from the row and the result word is loaded once the output
// is empty or out_ready is high. A new request is taken in the cycle after the
// result is loaded, while that result may still wait for out_ready. Position
// wraps to 4 bits when CAPACITY exceeds 16, entry_count to 5 bits above 31.

module sorted_key_set #(
    parameter int CAPACITY = sks_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sks_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output sks_pkg::out_t out_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    sks_pkg::state_t state_reg, state_next;
    sks_pkg::in_t    req_reg;
    logic [CW-1:0]   count_reg, count_next;
    sks_pkg::status_t status_reg, status_next;
    logic [3:0]      pos_reg, pos_next;
    sks_pkg::out_t   out_reg, out_next;
    logic            out_valid_reg, out_valid_next;
    logic            load;

    sks_pkg::cell_ctl_t   ctl;
    sks_pkg::cell_flags_t flags [CAPACITY];
    logic signed [sks_pkg::KEY_W-1:0] keys [CAPACITY];

    logic            hit;
    logic [3:0]      rank_pos;
    logic signed [sks_pkg::KEY_W-1:0] last_sel;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                             prev_lt;
            logic signed [sks_pkg::KEY_W-1:0] left_key;
            logic signed [sks_pkg::KEY_W-1:0] right_key;

            if (gi == 0)
            begin : g_first
                assign prev_lt  = 1'b1;
                assign left_key = req_reg.key;
            end
            else
            begin : g_mid
                assign prev_lt  = flags[gi-1].lt;
                assign left_key = keys[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_end
                assign right_key = keys[gi];
            end
            else
            begin : g_inner
                assign right_key = keys[gi+1];
            end

            sks_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .clk       (clk),
                .count     (count_reg),
                .req_key   (req_reg.key),
                .ctl       (ctl),
                .prev_lt   (prev_lt),
                .left_key  (left_key),
                .right_key (right_key),
                .key       (keys[gi]),
                .flags     (flags[gi])
            );
        end
    endgenerate

    // match and rank gathered over the row
    always_comb
    begin
        hit      = 1'b0;
        rank_pos = '0;
        last_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit = hit | flags[i].eq;
            if (flags[i].at_rank)
            begin
                rank_pos = rank_pos | 4'(i);
            end
            if (flags[i].is_last)
            begin
                last_sel = last_sel | keys[i];
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        ctl         = '0;
        load        = 1'b0;
        in_ready    = 1'b0;
        out_next    = out_reg;

        case (state_reg)
            sks_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = sks_pkg::ST_EXEC;
                end
            end
            sks_pkg::ST_EXEC:
            begin
                status_next = sks_pkg::STATUS_OK;
                pos_next    = '0;
                case (req_reg.action)
                    sks_pkg::ACT_INSERT:
                    begin
                        if (hit)
                        begin
                            status_next = sks_pkg::STATUS_DUP;
                            pos_next    = rank_pos;
                        end
                        else if (count_reg >= CAP_C)
                        begin
                            status_next = sks_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            ctl.ins    = 1'b1;
                            count_next = count_reg + 1'b1;
                            pos_next   = rank_pos;
                        end
                    end
                    sks_pkg::ACT_DELETE:
                    begin
                        if (hit)
                        begin
                            ctl.del    = 1'b1;
                            count_next = count_reg - 1'b1;
                            pos_next   = rank_pos;
                        end
                        else
                        begin
                            status_next = sks_pkg::STATUS_ABSENT;
                        end
                    end
                    sks_pkg::ACT_SEARCH:
                    begin
                        if (hit)
                        begin
                            pos_next = rank_pos;
                        end
                        else
                        begin
                            status_next = sks_pkg::STATUS_ABSENT;
                        end
                    end
                    sks_pkg::ACT_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
                state_next = sks_pkg::ST_FIN;
            end
            sks_pkg::ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load                 = 1'b1;
                    out_next.status      = status_reg;
                    out_next.position    = pos_reg;
                    out_next.entry_count = 5'(count_reg);
                    out_next.is_empty    = count_reg == '0;
                    out_next.first_key   = (count_reg == '0) ? '0 : keys[0];
                    out_next.last_key    = last_sel;
                    state_next           = sks_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sks_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sks_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
        status_reg <= status_next;
        pos_reg    <= pos_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
